// ===== rtl/all_different_closest_pair_defines.svh =====
// assertion macros for the closest pair block
// used by the port checker, no other dependencies
`ifndef ALL_DIFFERENT_CLOSEST_PAIR_DEFINES_SVH
`define ALL_DIFFERENT_CLOSEST_PAIR_DEFINES_SVH

// same-cycle implication
`define ADCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ADCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/adcp_pkg.sv =====
// shared constants and types of the closest pair block
// no dependencies
package adcp_pkg;

    localparam int MAX_SET = 32;
    localparam int VAL_W   = 32;
    localparam int COL_W   = 20;
    localparam int INF_W   = 16;

    localparam logic [INF_W:0] ONE_Q16     = 17'h10000;
    localparam logic [INF_W:0] ONE_Q16_RND = 17'h10001;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
        logic [COL_W-1:0] column;
    } t_cell_data;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_SCAN = 2'b10
    } t_state;

endpackage

// ===== rtl/adcp_cell.sv =====
// one cell of the sorting chain: holds one member, inserts or shifts toward the head
// depends on adcp_pkg
module adcp_cell
    import adcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_cell_data i_new,
    input  t_cell_data i_left,
    input  logic       i_left_gt,
    input  t_cell_data i_right,
    output t_cell_data o_data,
    output logic       o_gt
);

    t_cell_data r_data;
    t_cell_data n_data;

    // empty cells count as greater than anything
    assign o_gt   = !r_data.valid || (r_data.value > i_new.value);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = i_right;
        end else if (i_ctl.insert && o_gt) begin
            n_data = i_left_gt ? i_left : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else begin
            r_data <= n_data;
        end
    end

endmodule

// ===== rtl/all_different_closest_pair.sv =====
// Closest pair finder. Members (value, column) are taken one request per cycle into a chain
// of MAX_SET sorting cells that keeps them in ascending value order, equal values in arrival
// order; members beyond MAX_SET are dropped. The request flagged last_member starts a scan
// that shifts the chain out through the head cell, one member per cycle; once the chain is
// empty the result is loaded and the next set may start. Input requests are refused during
// the scan. A result left waiting on the output holds the end of the next scan only.
// depends on adcp_pkg and adcp_cell
module all_different_closest_pair
    import adcp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             i_ready,
    input  logic [VAL_W-1:0] i_value,
    input  logic [COL_W-1:0] i_column,
    input  logic             i_last_member,
    output logic             o_valid,
    input  logic             o_ready,
    output logic             o_infeasible,
    output logic [INF_W-1:0] o_infeasibility,
    output logic [COL_W-1:0] o_first_column,
    output logic [COL_W-1:0] o_second_column
);

    t_state     r_state, n_state;
    t_cell_ctl  w_ctl;
    t_cell_data w_new;
    t_cell_data w_data [MAX_SET];
    logic       w_gt   [MAX_SET];
    logic       w_accept;
    logic       w_full;

    logic             r_have_prev;
    logic [VAL_W-1:0] r_prev_val;
    logic [COL_W-1:0] r_prev_col;
    logic [INF_W:0]   r_closest;
    logic [COL_W-1:0] r_lo_col;
    logic [COL_W-1:0] r_hi_col;
    logic             r_found;
    logic [VAL_W-1:0] w_gap;
    logic             w_better;
    logic             w_done;
    logic [INF_W:0]   w_half;

    logic             r_out_valid;
    logic             r_out_inf;
    logic [INF_W-1:0] r_out_infeas;
    logic [COL_W-1:0] r_out_first;
    logic [COL_W-1:0] r_out_second;

    assign i_ready  = (r_state == S_LOAD);
    assign w_accept = i_valid && i_ready;
    assign w_full   = w_data[MAX_SET-1].valid;

    assign w_new.valid  = 1'b1;
    assign w_new.value  = i_value;
    assign w_new.column = i_column;

    assign w_ctl.insert = w_accept && !w_full;
    assign w_ctl.shift  = (r_state == S_SCAN);

    for (genvar g = 0; g < MAX_SET; g++) begin : g_cell
        t_cell_data w_left;
        t_cell_data w_right;
        logic       w_left_gt;
        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_gt = 1'b0;
        end else begin : g_body
            assign w_left    = w_data[g-1];
            assign w_left_gt = w_gt[g-1];
        end
        if (g == MAX_SET - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end
        adcp_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_new     (w_new),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .o_data    (w_data[g]),
            .o_gt      (w_gt[g])
        );
    end

    // scan at the chain head
    assign w_gap    = w_data[0].value - r_prev_val;
    assign w_better = w_data[0].valid && r_have_prev
                      && (w_gap < {{(VAL_W-INF_W-1){1'b0}}, r_closest});
    assign w_done   = (r_state == S_SCAN) && !w_data[0].valid
                      && (!r_out_valid || o_ready);
    assign w_half   = ONE_Q16_RND - r_closest;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (w_accept && i_last_member) n_state = S_SCAN;
            S_SCAN: if (w_done) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_have_prev <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_last_member) begin
                r_have_prev <= 1'b0;
                r_found     <= 1'b0;
                r_closest   <= ONE_Q16;
            end else if (r_state == S_SCAN && w_data[0].valid) begin
                r_have_prev <= 1'b1;
                r_prev_val  <= w_data[0].value;
                r_prev_col  <= w_data[0].column;
                if (w_better) begin
                    r_found   <= 1'b1;
                    r_closest <= w_gap[INF_W:0];
                    r_lo_col  <= r_prev_col;
                    r_hi_col  <= w_data[0].column;
                end
            end
            if (w_done) begin
                r_out_valid  <= 1'b1;
                r_out_inf    <= r_found;
                r_out_infeas <= r_found ? w_half[INF_W:1] : '0;
                r_out_first  <= r_found ? r_lo_col : '0;
                r_out_second <= r_found ? r_hi_col : '0;
            end else if (o_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_infeasible    = r_out_inf;
    assign o_infeasibility = r_out_infeas;
    assign o_first_column  = r_out_first;
    assign o_second_column = r_out_second;

endmodule

// ===== rtl/adcp_checker.sv =====
// port checker for the closest pair block, bound to the top level
// depends on adcp_pkg and all_different_closest_pair_defines.svh
`include "all_different_closest_pair_defines.svh"

module adcp_checker
    import adcp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic             i_last_member,
    input logic             o_valid,
    input logic             o_ready,
    input logic             o_infeasible,
    input logic [INF_W-1:0] o_infeasibility,
    input logic [COL_W-1:0] o_first_column,
    input logic [COL_W-1:0] o_second_column
);

    `ADCP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !o_ready, o_valid && $stable(o_infeasibility) && $stable(o_first_column) && $stable(o_infeasible), "stalled result changed")
    `ADCP_ASSERT_NOW(a_feasible_zero, i_clk, i_rst_n, o_valid && !o_infeasible, o_infeasibility == '0 && o_first_column == '0 && o_second_column == '0, "feasible result not zero")
    `ADCP_ASSERT_NOW(a_infeas_range, i_clk, i_rst_n, o_valid && o_infeasible, o_infeasibility != '0 && o_infeasibility <= 16'h8000, "infeasibility out of range")
    `ADCP_ASSERT_NEXT(a_scan_blocks, i_clk, i_rst_n, i_valid && i_ready && i_last_member, !i_ready, "request taken during scan")

endmodule

bind all_different_closest_pair adcp_checker u_adcp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .i_ready         (i_ready),
    .i_last_member   (i_last_member),
    .o_valid         (o_valid),
    .o_ready         (o_ready),
    .o_infeasible    (o_infeasible),
    .o_infeasibility (o_infeasibility),
    .o_first_column  (o_first_column),
    .o_second_column (o_second_column)
);
